FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bba_pkg.sv
// Types and constants for the bitmap block allocator.
`timescale 1ns / 1ps
package bba_pkg;
    localparam int unsigned MAX_GROUPS      = 16;
    localparam int unsigned MAX_BPG         = 8192;
    localparam int unsigned WORD_BITS       = 32;
    localparam int unsigned WORDS_PER_GROUP = MAX_BPG / WORD_BITS;
    localparam int unsigned GRP_W           = $clog2(MAX_GROUPS);
    localparam int unsigned WIDX_W          = $clog2(WORDS_PER_GROUP);
    localparam int unsigned BIT_W           = $clog2(WORD_BITS);
    localparam int unsigned BM_ADDR_W       = GRP_W + WIDX_W;
    localparam int unsigned CNT_W           = 14;
    localparam int unsigned TOTAL_W         = 18;
    localparam int unsigned HINT_W          = 5;
    localparam int unsigned BLOCK_W         = 18;

    typedef enum logic [1:0] {
        CMD_LOAD_WORD  = 2'd0,
        CMD_LOAD_COUNT = 2'd1,
        CMD_LOAD_TOTAL = 2'd2,
        CMD_ALLOC      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOSPACE      = 2'd1,
        ST_INCONSISTENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_BPG   = 2'd0,
        REG_FDB   = 2'd1,
        REG_GCNT  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_COUNT,
        FSM_WORD
    } fsm_t;

    typedef struct packed {
        logic                 we;
        logic [BM_ADDR_W-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [BM_ADDR_W-1:0] raddr;
    } bm_req_t;

    typedef struct packed {
        logic             we;
        logic [GRP_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic [GRP_W-1:0] raddr;
    } cnt_req_t;
endpackage

FILE: rtl/core/bba_bitmap_mem.sv
// Used-block bitmap memory, one write and one registered read port.
`timescale 1ns / 1ps
module bba_bitmap_mem
(
    input  logic                              clk,
    input  bba_pkg::bm_req_t                  req,
    output logic [bba_pkg::WORD_BITS-1:0]     rdata
);
    logic [bba_pkg::WORD_BITS-1:0] mem [0:(1 << bba_pkg::BM_ADDR_W)-1];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end
endmodule

FILE: rtl/core/bba_count_mem.sv
// Per-group free count memory, one write and one registered read port.
`timescale 1ns / 1ps
module bba_count_mem
(
    input  logic                          clk,
    input  bba_pkg::cnt_req_t             req,
    output logic [bba_pkg::CNT_W-1:0]     rdata
);
    logic [bba_pkg::CNT_W-1:0] mem [0:bba_pkg::MAX_GROUPS-1];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end
endmodule

FILE: rtl/core/bba_ctrl.sv
// Command sequencer: loads, group scan and bitmap word scan.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [13:0]                       bpg_eff,
    input  logic                              fdb,
    input  logic [bba_pkg::HINT_W-1:0]        gc_eff,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_cmd,
    input  logic [bba_pkg::GRP_W-1:0]         in_group,
    input  logic [bba_pkg::WIDX_W-1:0]        in_widx,
    input  logic [31:0]                       in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bba_pkg::BLOCK_W-1:0]       out_block,
    output logic [1:0]                        out_status,
    output bba_pkg::bm_req_t                  bm_req,
    input  logic [bba_pkg::WORD_BITS-1:0]     bm_rdata,
    output bba_pkg::cnt_req_t                 cnt_req,
    input  logic [bba_pkg::CNT_W-1:0]         cnt_rdata
);
    bba_pkg::fsm_t                  state_reg, state_next;
    logic [bba_pkg::HINT_W-1:0]     g_reg, g_next;
    logic [bba_pkg::WIDX_W-1:0]     w_reg, w_next;
    logic [bba_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [bba_pkg::BLOCK_W-1:0]    prod_reg, prod_next;
    logic [bba_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [bba_pkg::HINT_W-1:0]     hint_reg, hint_next;
    logic                           ovalid_reg, ovalid_next;
    logic [bba_pkg::BLOCK_W-1:0]    oblock_reg, oblock_next;
    logic [1:0]                     ostat_reg, ostat_next;

    logic [bba_pkg::HINT_W-1:0]     g_inc;
    logic [13:0]                    base;
    logic [13:0]                    rem;
    logic [bba_pkg::WORD_BITS-1:0]  free_bits;
    logic [bba_pkg::WORD_BITS-1:0]  low_bit;
    logic [bba_pkg::BIT_W-1:0]      bit_pos;
    logic [bba_pkg::CNT_W-1:0]      cnt_dec;
    logic [18:0]                    prod_full;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bba_pkg::FSM_IDLE;
            total_reg  <= '0;
            hint_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            hint_reg   <= hint_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        g_reg      <= g_next;
        w_reg      <= w_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        oblock_reg <= oblock_next;
        ostat_reg  <= ostat_next;
    end

    // Word scan datapath: mask unused tail bits, pick the lowest free bit
    always_comb
    begin
        base      = {1'b0, w_reg, {bba_pkg::BIT_W{1'b0}}};
        rem       = bpg_eff - base;
        free_bits = ~bm_rdata;
        if (rem < 14'(bba_pkg::WORD_BITS))
        begin
            free_bits = free_bits & ((32'd1 << rem[bba_pkg::BIT_W-1:0]) - 32'd1);
        end
        low_bit = free_bits & (~free_bits + 32'd1);
        bit_pos = '0;
        for (int i = 0; i < bba_pkg::WORD_BITS; i++)
        begin
            if (low_bit[i])
            begin
                bit_pos = bba_pkg::BIT_W'(i);
            end
        end
        cnt_dec   = cnt_reg - 14'd1;
        g_inc     = g_reg + 5'd1;
        prod_full = 19'(g_reg) * 19'(bpg_eff);
    end

    // Next state and memory requests
    always_comb
    begin
        state_next  = state_reg;
        g_next      = g_reg;
        w_next      = w_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        total_next  = total_reg;
        hint_next   = hint_reg;
        ovalid_next = ovalid_reg;
        oblock_next = oblock_reg;
        ostat_next  = ostat_reg;
        bm_req      = '0;
        cnt_req     = '0;
        in_ready    = 1'b0;

        // Drop the result once the transfer completes
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            bba_pkg::FSM_IDLE:
            begin
                in_ready = !ovalid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    ovalid_next = 1'b1;
                    oblock_next = '0;
                    ostat_next  = bba_pkg::ST_OK;
                    case (in_cmd)
                        bba_pkg::CMD_LOAD_WORD:
                        begin
                            bm_req.we    = 1'b1;
                            bm_req.waddr = {in_group, in_widx};
                            bm_req.wdata = in_value;
                        end
                        bba_pkg::CMD_LOAD_COUNT:
                        begin
                            cnt_req.we    = 1'b1;
                            cnt_req.waddr = in_group;
                            cnt_req.wdata = in_value[bba_pkg::CNT_W-1:0];
                        end
                        bba_pkg::CMD_LOAD_TOTAL:
                        begin
                            total_next = in_value[bba_pkg::TOTAL_W-1:0];
                        end
                        default:
                        begin
                            if (total_reg == '0 || hint_reg >= gc_eff)
                            begin
                                ostat_next = bba_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                // Hold the result until the scan finishes
                                ovalid_next   = 1'b0;
                                cnt_req.raddr = hint_reg[bba_pkg::GRP_W-1:0];
                                g_next        = hint_reg;
                                state_next    = bba_pkg::FSM_COUNT;
                            end
                        end
                    endcase
                end
            end

            bba_pkg::FSM_COUNT:
            begin
                if (cnt_rdata == '0)
                begin
                    if (g_inc >= gc_eff)
                    begin
                        hint_next   = gc_eff;
                        ovalid_next = 1'b1;
                        oblock_next = '0;
                        ostat_next  = bba_pkg::ST_NOSPACE;
                        state_next  = bba_pkg::FSM_IDLE;
                    end
                    else
                    begin
                        g_next        = g_inc;
                        cnt_req.raddr = g_inc[bba_pkg::GRP_W-1:0];
                    end
                end
                else
                begin
                    hint_next    = g_reg;
                    cnt_next     = cnt_rdata;
                    prod_next    = prod_full[bba_pkg::BLOCK_W-1:0];
                    w_next       = '0;
                    bm_req.raddr = {g_reg[bba_pkg::GRP_W-1:0], {bba_pkg::WIDX_W{1'b0}}};
                    state_next   = bba_pkg::FSM_WORD;
                end
            end

            bba_pkg::FSM_WORD:
            begin
                if (base >= bpg_eff)
                begin
                    ovalid_next = 1'b1;
                    oblock_next = '0;
                    ostat_next  = bba_pkg::ST_INCONSISTENT;
                    state_next  = bba_pkg::FSM_IDLE;
                end
                else if (free_bits != '0)
                begin
                    // Claim the bit and update both counts
                    bm_req.we     = 1'b1;
                    bm_req.waddr  = {g_reg[bba_pkg::GRP_W-1:0], w_reg};
                    bm_req.wdata  = bm_rdata | low_bit;
                    cnt_req.we    = 1'b1;
                    cnt_req.waddr = g_reg[bba_pkg::GRP_W-1:0];
                    cnt_req.wdata = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        hint_next = g_inc;
                    end
                    total_next  = total_reg - 18'd1;
                    ovalid_next = 1'b1;
                    oblock_next = prod_reg + 18'(fdb) + 18'(base) + 18'(bit_pos);
                    ostat_next  = bba_pkg::ST_OK;
                    state_next  = bba_pkg::FSM_IDLE;
                end
                else if (w_reg == {bba_pkg::WIDX_W{1'b1}})
                begin
                    ovalid_next = 1'b1;
                    oblock_next = '0;
                    ostat_next  = bba_pkg::ST_INCONSISTENT;
                    state_next  = bba_pkg::FSM_IDLE;
                end
                else
                begin
                    // Advance to the next word, one read per cycle
                    w_next       = w_reg + 8'd1;
                    bm_req.raddr = {g_reg[bba_pkg::GRP_W-1:0], w_reg + 8'd1};
                end
            end

            default:
            begin
                state_next = bba_pkg::FSM_IDLE;
            end
        endcase
    end

    assign out_valid  = ovalid_reg;
    assign out_block  = oblock_reg;
    assign out_status = ostat_reg;

    `BBA_ASSERT(a_hint_range, hint_reg <= 5'(bba_pkg::MAX_GROUPS), "hint past group range")
    `BBA_ASSERT_IMPL(a_ready_idle, in_ready, state_reg == bba_pkg::FSM_IDLE, "ready while busy")
    `BBA_ASSERT_IMPL(a_bm_write, bm_req.we,
        state_reg == bba_pkg::FSM_IDLE || state_reg == bba_pkg::FSM_WORD, "stray bitmap write")
    `BBA_ASSERT_IMPL(a_scan_quiet, state_reg != bba_pkg::FSM_IDLE, !ovalid_reg,
        "result pending during scan")
endmodule

FILE: rtl/core/bitmap_block_allocator_unit.sv
// Top level of the bitmap block allocator.
// Input channel s_*: one transfer carries a command (load bitmap word, load
// group free count, load total free count, allocate) with group, word index
// and value. Output channel m_*: exactly one transfer per command, carrying
// the block number and status. Configuration via cfg_we/cfg_addr/cfg_wdata.
// For a load, the result is registered the cycle after the input transfer.
// An allocate first reads group counts from the hint (up to 16, one count
// memory read per cycle), then bitmap words of the first group with a
// nonzero count (up to 256, one bitmap memory read per cycle). One
// command is processed at a time. The next command is taken in the cycle a
// pending result transfers. Reset clears the total free count and hint and
// sets the registers to 8192 blocks per group, first data block 1 and 16
// groups; bitmap words and group counts must be loaded before they are used.
// When the receiver stalls, the result holds in the output register and no
// new command is taken.
`timescale 1ns / 1ps
module bitmap_block_allocator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[1:0], group[5:2], word_index[13:6], value[45:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // block_number[17:0], status[19:18]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [13:0] cfg_wdata
);
    logic [13:0]                    bpg_reg;
    logic                           fdb_reg;
    logic [4:0]                     gcnt_reg;
    logic [13:0]                    bpg_eff;
    logic [bba_pkg::HINT_W-1:0]     gc_eff;
    bba_pkg::bm_req_t               bm_req;
    bba_pkg::cnt_req_t              cnt_req;
    logic [bba_pkg::WORD_BITS-1:0]  bm_rdata;
    logic [bba_pkg::CNT_W-1:0]      cnt_rdata;
    logic [bba_pkg::BLOCK_W-1:0]    out_block;
    logic [1:0]                     out_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpg_reg  <= 14'd8192;
            fdb_reg  <= 1'b1;
            gcnt_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bba_pkg::REG_BPG:  bpg_reg  <= cfg_wdata;
                bba_pkg::REG_FDB:  fdb_reg  <= cfg_wdata[0];
                bba_pkg::REG_GCNT: gcnt_reg <= cfg_wdata[4:0];
                default:           ;
            endcase
        end
    end

    // Clamp to the built storage size
    assign bpg_eff = (bpg_reg > 14'(bba_pkg::MAX_BPG)) ? 14'(bba_pkg::MAX_BPG) : bpg_reg;
    assign gc_eff  = (gcnt_reg > 5'(bba_pkg::MAX_GROUPS)) ? 5'(bba_pkg::MAX_GROUPS) : gcnt_reg;

    bba_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bpg_eff    (bpg_eff),
        .fdb        (fdb_reg),
        .gc_eff     (gc_eff),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tdata[1:0]),
        .in_group   (s_tdata[5:2]),
        .in_widx    (s_tdata[13:6]),
        .in_value   (s_tdata[45:14]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_block  (out_block),
        .out_status (out_status),
        .bm_req     (bm_req),
        .bm_rdata   (bm_rdata),
        .cnt_req    (cnt_req),
        .cnt_rdata  (cnt_rdata)
    );

    bba_bitmap_mem u_bitmap
    (
        .clk   (clk),
        .req   (bm_req),
        .rdata (bm_rdata)
    );

    bba_count_mem u_count
    (
        .clk   (clk),
        .req   (cnt_req),
        .rdata (cnt_rdata)
    );

    assign m_tdata = {4'd0, out_status, out_block};
endmodule
